// ===== rtl/core/bblc_pkg.sv =====
// bblc_pkg: shared widths, command codes and controller/datapath structs
// for the byte budget lru cache core. no dependencies.
package bblc_pkg;
  localparam int Entries   = 32;
  localparam int KeyBits   = 64;
  localparam int SizeBits  = 32;
  localparam int IdxW      = $clog2(Entries);
  localparam int CntW      = $clog2(Entries + 1);
  localparam int BudgetW   = 40;
  localparam int TotalW    = 38;
  localparam int TotOutW   = 37;
  localparam int CmdW      = 3;
  localparam logic [BudgetW-1:0] BudgetReset = 40'd1073741824;

  localparam logic [CmdW-1:0] CmdStore  = 3'd0;
  localparam logic [CmdW-1:0] CmdLoad   = 3'd1;
  localparam logic [CmdW-1:0] CmdLookup = 3'd2;
  localparam logic [CmdW-1:0] CmdEvict  = 3'd3;
  localparam logic [CmdW-1:0] CmdClear  = 3'd4;

  typedef struct packed {
    logic [CmdW-1:0]     command;
    logic [KeyBits-1:0]  block_key;
    logic [SizeBits-1:0] block_bytes;
  } req_t;

  typedef struct packed {
    logic               evicted;
    logic [KeyBits-1:0] evicted_key;
    logic               hit;
    logic [TotOutW-1:0] total_bytes;
    logic [5:0]         entry_count;
    logic               last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;   // capture request, start scan
    logic scan_step;  // compare one entry
    logic drop_hit;   // remove matched entry
    logic touch_hit;  // make matched entry newest
    logic clear_all;
    logic evict_step; // remove least recent entry
    logic insert;
    logic emit_evict;
    logic emit_final;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               scan_done;
    logic               found;
    logic               need_evict;
    logic [CmdW-1:0]    command;
  } stat_t;
endpackage

// ===== rtl/core/bblc_stream_if.sv =====
// bblc_stream_if: valid/ready channel carrying a payload of type t.
// depends on nothing.
interface bblc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bblc_ctrl.sv =====
// bblc_ctrl: command sequencer of the cache core.
// depends on bblc_pkg.
module bblc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  bblc_pkg::stat_t stat_i,
  output bblc_pkg::cmd_t  cmd_o
);
  import bblc_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScan  = 6'b000010,
    StAct   = 6'b000100,
    StEvict = 6'b001000,
    StIns   = 6'b010000,
    StFin   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = StAct;
      end
      StAct: begin
        state_d = StFin;
        case (stat_i.command)
          CmdStore: begin
            cmd_o.drop_hit = stat_i.found;
            state_d = StEvict;
          end
          CmdLoad:  cmd_o.touch_hit = stat_i.found;
          CmdEvict: cmd_o.drop_hit = stat_i.found;
          CmdClear: cmd_o.clear_all = 1'b1;
          default: ;
        endcase
      end
      StEvict: begin
        if (!out_busy_i) begin
          if (stat_i.need_evict) begin
            cmd_o.evict_step = 1'b1;
            cmd_o.emit_evict = 1'b1;
          end else begin
            cmd_o.insert = 1'b1;
            state_d = StIns;
          end
        end
      end
      StIns: state_d = StFin;
      StFin: begin
        if (!out_busy_i) begin
          cmd_o.emit_final = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule

// ===== rtl/core/bblc_datapath.sv =====
// bblc_datapath: entry table, rank update, byte total and result register.
// depends on bblc_pkg.
module bblc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bblc_pkg::req_t                req_i,
  input  logic [bblc_pkg::BudgetW-1:0]  budget_i,
  input  bblc_pkg::cmd_t                cmd_i,
  output bblc_pkg::stat_t               stat_o,
  output bblc_pkg::rsp_t                rsp_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i
);
  import bblc_pkg::*;

  logic [Entries-1:0]                valid_q;
  logic [Entries-1:0][KeyBits-1:0]   key_q;
  logic [Entries-1:0][SizeBits-1:0]  size_q;
  logic [Entries-1:0][IdxW-1:0]      rank_q;
  logic [TotalW-1:0]                 total_q;
  logic [CntW-1:0]                   count_q;
  req_t                              req_q;
  logic [IdxW-1:0]                   scan_q;
  logic                              found_q, hit_q;
  logic [IdxW-1:0]                   hidx_q;
  rsp_t                              rsp_q;
  logic                              rsp_valid_q;

  // pick of the free entry and of the least recent one
  logic [Entries-1:0] free_oh;
  logic [IdxW-1:0]    oldest_idx, free_idx, tgt_idx;
  logic               do_drop, do_touch;
  logic [TotalW-1:0]  need_sum;

  always_comb begin
    oldest_idx = '0;
    free_idx = '0;
    free_oh = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && rank_q[i] == '0) begin
        oldest_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_oh = '0;
        free_oh[i] = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign do_drop  = cmd_i.drop_hit | cmd_i.evict_step;
  assign do_touch = cmd_i.touch_hit;
  assign tgt_idx  = cmd_i.evict_step ? oldest_idx : hidx_q;
  assign need_sum = total_q + TotalW'(req_q.block_bytes);

  assign stat_o.scan_done  = (scan_q == IdxW'(Entries - 1));
  assign stat_o.found      = found_q;
  assign stat_o.command    = req_q.command;
  assign stat_o.need_evict = (count_q != '0) &&
      (({2'b0, need_sum} > budget_i) || (count_q >= CntW'(Entries)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      total_q <= '0;
      count_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_evict || cmd_i.emit_final) rsp_valid_q <= 1'b1;
      else if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (do_drop || do_touch) begin
        for (int i = 0; i < Entries; i++) begin
          if (IdxW'(i) != tgt_idx && valid_q[i] && rank_q[i] > rank_q[tgt_idx])
            rank_q[i] <= rank_q[i] - 1'b1;
        end
      end
      if (do_drop) begin
        valid_q[tgt_idx] <= 1'b0;
        count_q <= count_q - 1'b1;
        total_q <= (total_q >= TotalW'(size_q[tgt_idx])) ?
                   total_q - TotalW'(size_q[tgt_idx]) : '0;
      end
      if (do_touch) rank_q[tgt_idx] <= IdxW'(count_q - 1'b1);
      if (cmd_i.clear_all) begin
        valid_q <= '0;
        count_q <= '0;
        total_q <= '0;
      end
      if (cmd_i.insert && free_oh != '0) begin
        valid_q[free_idx] <= 1'b1;
        key_q[free_idx]   <= req_q.block_key;
        size_q[free_idx]  <= req_q.block_bytes;
        rank_q[free_idx]  <= IdxW'(count_q);
        count_q <= count_q + 1'b1;
        total_q <= need_sum;
      end
    end
  end

  // the evict report shows totals after the drop
  logic [TotalW-1:0] tot_after;
  logic [CntW-1:0]   cnt_after;
  assign tot_after = (total_q >= TotalW'(size_q[oldest_idx])) ?
                     total_q - TotalW'(size_q[oldest_idx]) : '0;
  assign cnt_after = count_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q   <= req_i;
      scan_q  <= '0;
      found_q <= 1'b0;
      hidx_q  <= '0;
    end
    if (cmd_i.scan_step) begin
      if (valid_q[scan_q] && key_q[scan_q] == req_q.block_key && !found_q) begin
        found_q <= 1'b1;
        hidx_q  <= scan_q;
      end
      if (!stat_o.scan_done) scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.load_req) hit_q <= 1'b0;
    else if (cmd_i.scan_step && stat_o.scan_done)
      hit_q <= found_q || (valid_q[scan_q] && key_q[scan_q] == req_q.block_key);
    else if (cmd_i.clear_all) hit_q <= 1'b0;
    else if (cmd_i.emit_final && req_q.command > CmdClear) hit_q <= 1'b0;
    if (cmd_i.emit_evict) begin
      rsp_q.evicted     <= 1'b1;
      rsp_q.evicted_key <= key_q[oldest_idx];
      rsp_q.hit         <= hit_q;
      rsp_q.total_bytes <= tot_after[TotOutW-1:0];
      rsp_q.entry_count <= 6'(cnt_after);
      rsp_q.last        <= 1'b0;
    end
    if (cmd_i.emit_final) begin
      rsp_q.evicted     <= 1'b0;
      rsp_q.evicted_key <= '0;
      rsp_q.hit         <= (req_q.command > CmdClear) ? 1'b0 : hit_q;
      rsp_q.total_bytes <= total_q[TotOutW-1:0];
      rsp_q.entry_count <= 6'(count_q);
      rsp_q.last        <= 1'b1;
    end
  end

  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_valid_q;
endmodule

// ===== rtl/core/byte_budget_lru_cache_core.sv =====
// byte_budget_lru_cache_core: top level of the cache core.
// depends on bblc_pkg, bblc_stream_if, bblc_ctrl and bblc_datapath.
//
// Size-aware lru table of 32 keyed blocks held to a byte budget. A load,
// lookup, evict, clear or unused command goes from its transfer through one
// capture, a serial key scan of all 32 entries, an action step and the final
// result before the next transfer can be taken; a store goes through the scan
// and action, one eviction step per evicted entry, an insert step, a settle
// step and the final result. Each eviction step, the insert and the final
// result wait while a held result is not taken. A store reports each
// eviction as a result with last low, then a final result. A result
// waits in an output register; the next command is taken once the final
// result is held there.
module byte_budget_lru_cache_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bblc_pkg::BudgetW-1:0] cfg_wdata_i,
  bblc_stream_if.sink                  req_if,
  bblc_stream_if.source                rsp_if
);
  import bblc_pkg::*;

  logic [BudgetW-1:0] budget_q;
  cmd_t  cmd;
  stat_t stat;
  logic  rsp_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) budget_q <= BudgetReset;
    else if (cfg_we_i) budget_q <= cfg_wdata_i;
  end

  bblc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_busy_i (rsp_valid && !rsp_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bblc_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i       (req_if.data),
    .budget_i    (budget_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (rsp_if.data),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_if.ready)
  );

  assign rsp_if.valid = rsp_valid;
endmodule

// ===== rtl/core/bblc_checker.sv =====
// bblc_checker: port-level assertions for the cache core, bound to the top.
// depends on bblc_pkg and byte_budget_lru_cache_core.
module bblc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input bblc_pkg::rsp_t out_data_i
);
  import bblc_pkg::*;

  // a held result stays put until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // final results never carry an evicted key
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.last |-> !out_data_i.evicted && out_data_i.evicted_key == '0)
    else $error("final result marks eviction");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.last != out_data_i.evicted)
    else $error("last and evicted disagree");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.entry_count <= 6'(Entries))
    else $error("entry count beyond table size");

  // a new command is not taken in the cycle after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");
endmodule

bind byte_budget_lru_cache_core bblc_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i  (req_if.valid),
  .in_ready_i  (req_if.ready),
  .out_valid_i (rsp_if.valid),
  .out_ready_i (rsp_if.ready),
  .out_data_i  (rsp_if.data)
);

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for byte_budget_lru_cache_core.
// depends on bblc_pkg, bblc_stream_if and the core rtl; predicts every result
// with its own lru table model and checks each transfer in order.
module tb_top;
  import bblc_pkg::*;

  localparam int NumDir = 24;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [BudgetW-1:0] cfg_wdata_i;

  bblc_stream_if #(.T(req_t)) req_ch ();
  bblc_stream_if #(.T(rsp_t)) rsp_ch ();

  byte_budget_lru_cache_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_if(req_ch.sink),
    .rsp_if(rsp_ch.source)
  );

  // predictor state
  logic                m_valid [Entries];
  logic [KeyBits-1:0]  m_key [Entries];
  logic [SizeBits-1:0] m_size [Entries];
  int unsigned         m_rank [Entries];
  logic [TotalW-1:0]   m_total;
  int unsigned         m_count;
  logic [BudgetW-1:0]  m_budget;

  // expected results in order, written at exp_wr and read at exp_rd
  rsp_t exp_mem [int];
  int   exp_wr;
  int   exp_rd;
  int   errors;
  bit   sink_hold;
  bit   no_idle;
  int   sent;

  // directed rows: expected single result checked at a glance when chk is set
  typedef struct packed {
    req_t req;
    bit   chk;
    rsp_t rsp;
  } dir_row_t;
  dir_row_t dir_tab [NumDir];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int find_entry(logic [KeyBits-1:0] k);
    for (int i = 0; i < Entries; i++)
      if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_at(int idx);
    int unsigned r;
    r = m_rank[idx];
    m_valid[idx] = 1'b0;
    for (int i = 0; i < Entries; i++)
      if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
    if (m_count > 0) m_count--;
    m_total = (m_total >= m_size[idx]) ? m_total - m_size[idx] : '0;
  endfunction

  function automatic rsp_t mk_rsp(bit ev, logic [KeyBits-1:0] k, bit h, bit l);
    rsp_t r;
    r.evicted = ev;
    r.evicted_key = k;
    r.hit = h;
    r.total_bytes = m_total[TotOutW-1:0];
    r.entry_count = m_count[5:0];
    r.last = l;
    return r;
  endfunction

  function automatic void add_expected(rsp_t r);
    exp_mem[exp_wr] = r;
    exp_wr++;
  endfunction

  function automatic void predict_cache(req_t q);
    int idx, old;
    bit h;
    logic [KeyBits-1:0] ok;
    idx = find_entry(q.block_key);
    h = (idx >= 0);
    case (q.command)
      CmdStore: begin
        if (idx >= 0) drop_at(idx);
        while (m_count > 0 && ({2'b0, m_total} + q.block_bytes > m_budget ||
               m_count >= Entries)) begin
          old = -1;
          for (int i = 0; i < Entries; i++)
            if (old < 0 && m_valid[i] && m_rank[i] == 0) old = i;
          if (old < 0) break;
          ok = m_key[old];
          drop_at(old);
          add_expected(mk_rsp(1'b1, ok, h, 1'b0));
        end
        for (int i = 0; i < Entries; i++)
          if (!m_valid[i]) begin
            m_valid[i] = 1'b1;
            m_key[i] = q.block_key;
            m_size[i] = q.block_bytes;
            m_rank[i] = m_count;
            m_count++;
            m_total = m_total + q.block_bytes;
            break;
          end
      end
      CmdLoad: begin
        if (idx >= 0) begin
          for (int i = 0; i < Entries; i++)
            if (i != idx && m_valid[i] && m_rank[i] > m_rank[idx]) m_rank[i]--;
          m_rank[idx] = m_count - 1;
        end
      end
      CmdLookup: ;
      CmdEvict: if (idx >= 0) drop_at(idx);
      CmdClear: begin
        for (int i = 0; i < Entries; i++) m_valid[i] = 1'b0;
        m_count = 0;
        m_total = '0;
        h = 1'b0;
      end
      default: h = 1'b0;
    endcase
    add_expected(mk_rsp(1'b0, '0, h, 1'b1));
  endfunction

  task automatic write_budget(logic [BudgetW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    m_budget = v;
  endtask

  // called at a falling edge; stops offering requests
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // one transfer on the request side; prediction runs at the accepting edge
  task automatic send_cmd(req_t q);
    while (!no_idle && $urandom_range(99) < 27) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_cache(q);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic req_t rand_cmd(int kpool);
    req_t q;
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) q.command = CmdStore;
    else if (sel < 62) q.command = CmdLoad;
    else if (sel < 77) q.command = CmdLookup;
    else if (sel < 92) q.command = CmdEvict;
    else if (sel < 96) q.command = CmdClear;
    else q.command = 3'($urandom_range(7, 5));
    // small key pool gives hits; a few fully random keys hit every bit
    if ($urandom_range(9) < 8) q.block_key = 64'($urandom_range(kpool));
    else q.block_key = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (sel < 6) q.block_bytes = 32'($urandom_range(4096));
    else if (sel < 9) q.block_bytes = $urandom;
    else q.block_bytes = {1'($urandom_range(1)), 31'h7fffffff};
    return q;
  endfunction

  // response side: random stall, forced long hold-off, field checks
  initial begin
    rsp_t exp_r;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 27);
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (exp_wr == exp_rd) begin
          $display("%0t unexpected result %p", $time, rsp_ch.data);
          errors++;
        end else begin
          exp_r = exp_mem[exp_rd];
          exp_mem.delete(exp_rd);
          exp_rd++;
          if (rsp_ch.data !== exp_r) begin
            $display("%0t mismatch expected %p actual %p", $time, exp_r, rsp_ch.data);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    req_t q;
    int wait_cnt;
    logic [BudgetW-1:0] budgets [4];
    errors = 0;
    sent = 0;
    exp_wr = 0;
    exp_rd = 0;
    sink_hold = 1'b0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    for (int i = 0; i < Entries; i++) begin
      m_valid[i] = 1'b0; m_key[i] = '0; m_size[i] = '0; m_rank[i] = 0;
    end
    m_total = '0;
    m_count = 0;
    m_budget = BudgetReset;

    dir_tab[0]  = '{'{CmdLookup, 64'd5, 32'd0}, 1, '{0, 0, 0, 37'd0, 6'd0, 1}};
    dir_tab[1]  = '{'{CmdLoad, 64'd5, 32'd0}, 1, '{0, 0, 0, 37'd0, 6'd0, 1}};
    dir_tab[2]  = '{'{CmdEvict, 64'd5, 32'd0}, 1, '{0, 0, 0, 37'd0, 6'd0, 1}};
    dir_tab[3]  = '{'{CmdStore, 64'd1, 32'd100}, 1, '{0, 0, 0, 37'd100, 6'd1, 1}};
    dir_tab[4]  = '{'{CmdStore, 64'd2, 32'd200}, 1, '{0, 0, 0, 37'd300, 6'd2, 1}};
    dir_tab[5]  = '{'{CmdStore, 64'd1, 32'd50}, 1, '{0, 0, 1, 37'd250, 6'd2, 1}};
    dir_tab[6]  = '{'{CmdLookup, 64'd2, 32'd0}, 1, '{0, 0, 1, 37'd250, 6'd2, 1}};
    dir_tab[7]  = '{'{CmdLoad, 64'd2, 32'd7}, 0, '0};
    dir_tab[8]  = '{'{CmdStore, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff}, 0, '0};
    dir_tab[9]  = '{'{CmdStore, 64'd0, 32'd0}, 0, '0};
    dir_tab[10] = '{'{CmdEvict, 64'd0, 32'd0}, 0, '0};
    dir_tab[11] = '{'{3'd5, 64'd1, 32'd1}, 0, '0};
    dir_tab[12] = '{'{3'd6, 64'd1, 32'd1}, 0, '0};
    dir_tab[13] = '{'{3'd7, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff}, 0, '0};
    dir_tab[14] = '{'{CmdClear, 64'd9, 32'd9}, 1, '{0, 0, 0, 37'd0, 6'd0, 1}};
    for (int i = 15; i < NumDir; i++)
      dir_tab[i] = '{'{CmdStore, 64'(i), 32'(i * 1000)}, 0, '0};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      send_cmd(dir_tab[i].req);
      if (dir_tab[i].chk && exp_mem[exp_wr - 1] !== dir_tab[i].rsp) begin
        $display("%0t directed row %0d expected %p actual %p", $time, i,
                 dir_tab[i].rsp, exp_mem[exp_wr - 1]);
        errors++;
      end
    end
    drain_results();

    // oversize store under a small budget flushes the table
    write_budget(40'd5000);
    send_cmd('{CmdStore, 64'd77, 32'd6000});
    drain_results();

    budgets[0] = 40'd0;
    budgets[1] = {BudgetW{1'b1}};
    budgets[2] = 40'd20000;
    budgets[3] = BudgetReset;
    for (int ph = 0; ph < 4; ph++) begin
      write_budget(budgets[ph]);
      for (int n = 0; n < 62; n++) begin
        no_idle = (ph == 2 && n < 30);
        if (ph == 1 && n == 10) begin
          // receiver holds off while requests keep coming
          fork
            begin
              sink_hold = 1'b1;
              wait_cnt = 0;
              while (wait_cnt < 300) begin
                @(negedge clk_i);
                wait_cnt++;
              end
              sink_hold = 1'b0;
            end
          join_none
        end
        if (ph == 3 && n == 20) drain_results();
        q = rand_cmd(ph == 1 ? 60 : 40);
        send_cmd(q);
      end
      no_idle = 1'b0;
      drain_results();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/bblc_pkg.sv
rtl/core/bblc_stream_if.sv
rtl/core/bblc_ctrl.sv
rtl/core/bblc_datapath.sv
rtl/core/byte_budget_lru_cache_core.sv
rtl/core/bblc_checker.sv
sim/tb_top.sv
